/* sv/braille_cell_encoder_top_macros.svh */
// ---------------------------------------------------------------------------
// Braille cell encoder assertion macros
// Shared property wrappers, clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BRAILLE_CELL_ENCODER_TOP_MACROS_SVH
`define BRAILLE_CELL_ENCODER_TOP_MACROS_SVH

// Same-cycle implication.
`define BCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bce_pkg.sv */
// ---------------------------------------------------------------------------
// Braille cell encoder package
// Word types, register codes and small helper functions.
// ---------------------------------------------------------------------------
package bce_pkg;

  localparam int unsigned NumSub     = 8;
  localparam int unsigned LumaW      = 10;  // max luma 762
  localparam int unsigned LumaSumW   = 13;
  localparam int unsigned ChanSumW   = 11;  // 8 x 255
  localparam int unsigned CountW     = 4;   // 0..8
  localparam int unsigned RecipW     = 17;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_RED   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_GREEN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_BLUE  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_MIN    = 2'd3;

  localparam logic [7:0] WeightRedRst   = 8'd54;
  localparam logic [7:0] WeightGreenRst = 8'd183;
  localparam logic [7:0] WeightBlueRst  = 8'd19;
  localparam logic [7:0] AlphaMinRst    = 8'd128;

  localparam logic [15:0] GlyphBase    = 16'h2800;
  localparam logic [7:0]  Utf8Lead3    = 8'hE0;
  localparam logic [7:0]  Utf8Cont     = 8'h80;
  localparam logic [5:0]  Utf8ContMask = 6'h3F;

  // subpixel index -> dot bit
  localparam logic [2:0] DotBit [NumSub] = '{3'd0, 3'd3, 3'd1, 3'd4,
                                             3'd2, 3'd5, 3'd6, 3'd7};

  typedef struct packed {
    logic [31:0] sub0_rgba;
    logic [31:0] sub1_rgba;
    logic [31:0] sub2_rgba;
    logic [31:0] sub3_rgba;
    logic [31:0] sub4_rgba;
    logic [31:0] sub5_rgba;
    logic [31:0] sub6_rgba;
    logic [31:0] sub7_rgba;
    logic [23:0] under_bg_rgb;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  dot_pattern;
    logic [23:0] glyph_utf8;
    logic [23:0] fg_rgb;
    logic [23:0] bg_rgb;
  } out_word_t;

  typedef struct packed {
    logic [7:0] weight_red;
    logic [7:0] weight_green;
    logic [7:0] weight_blue;
    logic [7:0] alpha_opaque_min;
  } cfg_t;

  typedef struct packed {
    logic             opaque;
    logic [LumaW-1:0] luma;
    logic [23:0]      rgb;
  } lane_t;

  typedef struct packed {
    logic [ChanSumW-1:0] r;
    logic [ChanSumW-1:0] g;
    logic [ChanSumW-1:0] b;
  } rgb_sum_t;

  typedef struct packed {
    logic [7:0]        pattern;
    logic [CountW-1:0] fg_n;
    logic [CountW-1:0] bg_n;
    rgb_sum_t          fg_sum;
    rgb_sum_t          bg_sum;
    logic [23:0]       under;
  } merge_t;

  // ceil(2^16 / n), exact floor division for sums below 2^11
  function automatic logic [RecipW-1:0] recip_of(input logic [CountW-1:0] n);
    logic [RecipW-1:0] m;
    case (n)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd5:    m = 17'd13108;
      4'd6:    m = 17'd10923;
      4'd7:    m = 17'd9363;
      4'd8:    m = 17'd8192;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [23:0] glyph_of(input logic [7:0] pattern);
    logic [15:0] cp;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    cp = GlyphBase + {8'd0, pattern};
    b0 = Utf8Lead3 | {4'd0, cp[15:12]};
    b1 = Utf8Cont | {2'd0, cp[11:6] & Utf8ContMask};
    b2 = Utf8Cont | {2'd0, cp[5:0] & Utf8ContMask};
    return {b0, b1, b2};
  endfunction

endpackage

/* sv/bce_lane.sv */
// ---------------------------------------------------------------------------
// Braille cell encoder subpixel lane
// Opacity test, background substitution and weighted luma of one subpixel.
// ---------------------------------------------------------------------------
module bce_lane (
  input  logic           clk_i,
  input  logic           en_i,
  input  bce_pkg::cfg_t  cfg_i,
  input  logic [31:0]    px_i,
  input  logic [23:0]    under_i,
  output bce_pkg::lane_t lane_o
);
  import bce_pkg::*;

  logic        opaque;
  logic [23:0] rgb;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic [17:0] acc;
  lane_t       lane_d;
  lane_t       lane_q;

  always_comb begin
    opaque = px_i[7:0] >= cfg_i.alpha_opaque_min;
    rgb    = opaque ? px_i[31:8] : under_i;
    prod_r = cfg_i.weight_red   * rgb[23:16];
    prod_g = cfg_i.weight_green * rgb[15:8];
    prod_b = cfg_i.weight_blue  * rgb[7:0];
    acc    = 18'(prod_r) + 18'(prod_g) + 18'(prod_b);
    lane_d.opaque = opaque;
    lane_d.luma   = acc[17:8];
    lane_d.rgb    = rgb;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

/* sv/bce_merge.sv */
// ---------------------------------------------------------------------------
// Braille cell encoder merge
// Threshold from the lane lumas, then lit mask, dot pattern and color sums.
// ---------------------------------------------------------------------------
module bce_merge (
  input  logic           clk_i,
  input  logic           thr_en_i,
  input  logic           lit_en_i,
  input  bce_pkg::lane_t lanes_i [bce_pkg::NumSub],
  input  logic [23:0]    under_i,
  output logic           any_opaque_o,
  output bce_pkg::merge_t merge_o
);
  import bce_pkg::*;

  // threshold stage
  logic [LumaSumW-1:0] luma_total;
  rgb_sum_t            tot_d;
  logic                any_d;
  lane_t               lanes_q [NumSub];
  logic [23:0]         under_q;
  logic [LumaW-1:0]    thr_q;
  rgb_sum_t            tot_q;
  logic                any_q;

  always_comb begin
    luma_total = '0;
    tot_d      = '0;
    any_d      = 1'b0;
    for (int i = 0; i < NumSub; i++) begin
      luma_total = luma_total + LumaSumW'(lanes_i[i].luma);
      tot_d.r    = tot_d.r + ChanSumW'(lanes_i[i].rgb[23:16]);
      tot_d.g    = tot_d.g + ChanSumW'(lanes_i[i].rgb[15:8]);
      tot_d.b    = tot_d.b + ChanSumW'(lanes_i[i].rgb[7:0]);
      any_d      = any_d | lanes_i[i].opaque;
    end
  end

  always_ff @(posedge clk_i) begin
    if (thr_en_i) begin
      lanes_q <= lanes_i;
      under_q <= under_i;
      thr_q   <= luma_total[LumaSumW-1:3];
      tot_q   <= tot_d;
      any_q   <= any_d;
    end
  end

  assign any_opaque_o = any_q;

  // lit stage
  merge_t merge_d;
  merge_t merge_q;
  logic   lit;

  always_comb begin
    merge_d = '0;
    lit     = 1'b0;
    for (int i = 0; i < NumSub; i++) begin
      lit = lanes_q[i].opaque && (lanes_q[i].luma >= thr_q);
      if (lit) begin
        merge_d.pattern[DotBit[i]] = 1'b1;
        merge_d.fg_sum.r = merge_d.fg_sum.r + ChanSumW'(lanes_q[i].rgb[23:16]);
        merge_d.fg_sum.g = merge_d.fg_sum.g + ChanSumW'(lanes_q[i].rgb[15:8]);
        merge_d.fg_sum.b = merge_d.fg_sum.b + ChanSumW'(lanes_q[i].rgb[7:0]);
        merge_d.fg_n     = merge_d.fg_n + 1'b1;
      end
    end
    merge_d.bg_sum.r = tot_q.r - merge_d.fg_sum.r;
    merge_d.bg_sum.g = tot_q.g - merge_d.fg_sum.g;
    merge_d.bg_sum.b = tot_q.b - merge_d.fg_sum.b;
    merge_d.bg_n     = CountW'(NumSub) - merge_d.fg_n;
    merge_d.under    = under_q;
  end

  always_ff @(posedge clk_i) begin
    if (lit_en_i) begin
      merge_q <= merge_d;
    end
  end

  assign merge_o = merge_q;

endmodule

/* sv/bce_mean.sv */
// ---------------------------------------------------------------------------
// Braille cell encoder mean and glyph stage
// Floor means by reciprocal multiply, UTF-8 glyph, output word register.
// ---------------------------------------------------------------------------
module bce_mean (
  input  logic               clk_i,
  input  logic               en_i,
  input  bce_pkg::merge_t    merge_i,
  output bce_pkg::out_word_t word_o
);
  import bce_pkg::*;

  localparam int unsigned ProdW = ChanSumW + RecipW;

  function automatic logic [7:0] mean_chan(input logic [ChanSumW-1:0] sum,
                                           input logic [RecipW-1:0]   m);
    logic [ProdW-1:0] prod;
    prod = ProdW'(sum) * ProdW'(m);
    return prod[RecipShift +: 8];
  endfunction

  logic [RecipW-1:0] fg_m;
  logic [RecipW-1:0] bg_m;
  out_word_t         word_d;
  out_word_t         word_q;

  always_comb begin
    fg_m = recip_of(merge_i.fg_n);
    bg_m = recip_of(merge_i.bg_n);
    word_d.dot_pattern = merge_i.pattern;
    word_d.glyph_utf8  = glyph_of(merge_i.pattern);
    // fall back to the cell background when a set is empty
    if (merge_i.fg_n == '0) begin
      word_d.fg_rgb = merge_i.under;
    end else begin
      word_d.fg_rgb = {mean_chan(merge_i.fg_sum.r, fg_m),
                       mean_chan(merge_i.fg_sum.g, fg_m),
                       mean_chan(merge_i.fg_sum.b, fg_m)};
    end
    if (merge_i.bg_n == '0) begin
      word_d.bg_rgb = merge_i.under;
    end else begin
      word_d.bg_rgb = {mean_chan(merge_i.bg_sum.r, bg_m),
                       mean_chan(merge_i.bg_sum.g, bg_m),
                       mean_chan(merge_i.bg_sum.b, bg_m)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

/* sv/braille_cell_encoder_top.sv */
// ---------------------------------------------------------------------------
// Braille cell encoder top level
// Turns one 2x4 RGBA cell into a braille dot pattern, its UTF-8 glyph and
// foreground/background colors, through a four-stage valid/stall pipeline.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+---------------------------
//   in      | into      | in_valid_i/in_stall_o  | in_word_i  (bce_pkg::in_word_t)
//   out     | out of    | out_valid_o/out_stall_i| out_word_o (bce_pkg::out_word_t)
//   cfg     | into      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Throughput is one cell per clock while out_stall_i is low. The accepting
// edge loads the lane stage; the cell then moves through the threshold, lit
// and mean register stages in order; out_valid_o shows the mean stage valid.
// A cell with no opaque subpixel is dropped after the threshold stage.
// Each stage advances when it is empty or the stage after it advances, so a
// stall on the output backs up one stage at a time; in_stall_o rises only
// when all four stages hold a word and out_stall_i holds the last one.
// rst_ni clears the stage valid bits and loads the default luma weights and
// alpha threshold; there is no clearing pass.
// ---------------------------------------------------------------------------
`include "braille_cell_encoder_top_macros.svh"

module braille_cell_encoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bce_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bce_pkg::out_word_t           out_word_o,
  input  logic                         cfg_we_i,
  input  logic [bce_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bce_pkg::CfgDataW-1:0] cfg_data_i
);
  import bce_pkg::*;

  // ---- configuration registers ----
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight_red       <= WeightRedRst;
      cfg_q.weight_green     <= WeightGreenRst;
      cfg_q.weight_blue      <= WeightBlueRst;
      cfg_q.alpha_opaque_min <= AlphaMinRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WEIGHT_RED:   cfg_q.weight_red       <= cfg_data_i;
        CFG_WEIGHT_GREEN: cfg_q.weight_green     <= cfg_data_i;
        CFG_WEIGHT_BLUE:  cfg_q.weight_blue      <= cfg_data_i;
        CFG_ALPHA_MIN:    cfg_q.alpha_opaque_min <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- pipeline control ----
  // adv_N: stage N loads this cycle (it is empty or its word moves on)
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic adv1, adv2, adv3, adv4;
  logic any_opaque;

  assign adv4 = !v4_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  always_comb begin
    v1_d = adv1 ? in_valid_i : v1_q;
    v2_d = adv2 ? v1_q : v2_q;
    // drop cells without any opaque subpixel
    v3_d = adv3 ? (v2_q && any_opaque) : v3_q;
    v4_d = adv4 ? v3_q : v4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  assign in_stall_o  = !adv1;
  assign out_valid_o = v4_q;

  // ---- subpixel lanes ----
  logic [31:0] sub_px [NumSub];
  lane_t       lanes [NumSub];

  assign sub_px[0] = in_word_i.sub0_rgba;
  assign sub_px[1] = in_word_i.sub1_rgba;
  assign sub_px[2] = in_word_i.sub2_rgba;
  assign sub_px[3] = in_word_i.sub3_rgba;
  assign sub_px[4] = in_word_i.sub4_rgba;
  assign sub_px[5] = in_word_i.sub5_rgba;
  assign sub_px[6] = in_word_i.sub6_rgba;
  assign sub_px[7] = in_word_i.sub7_rgba;

  // hold the cell background alongside the lanes
  logic [23:0] under_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      under_q <= in_word_i.under_bg_rgb;
    end
  end

  for (genvar gi = 0; gi < NumSub; gi++) begin : g_lane
    bce_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (adv1),
      .cfg_i   (cfg_q),
      .px_i    (sub_px[gi]),
      .under_i (in_word_i.under_bg_rgb),
      .lane_o  (lanes[gi])
    );
  end

  // ---- merge: threshold, lit mask, color sums ----
  merge_t merged;

  bce_merge u_merge (
    .clk_i        (clk_i),
    .thr_en_i     (adv2),
    .lit_en_i     (adv3),
    .lanes_i      (lanes),
    .under_i      (under_q),
    .any_opaque_o (any_opaque),
    .merge_o      (merged)
  );

  // ---- means, glyph and output register ----
  bce_mean u_mean (
    .clk_i   (clk_i),
    .en_i    (adv4),
    .merge_i (merged),
    .word_o  (out_word_o)
  );

  // ---- checks ----
  `BCE_ASSERT_IMPLY(a_stall_full, in_stall_o, v1_q && v2_q && v3_q && v4_q,
    "input stalled while the pipeline has a free stage")
  `BCE_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, v1_q,
    "accepted cell did not reach the lane stage")
  `BCE_ASSERT_IMPLY(a_out_drop, $fell(out_valid_o), $past(!out_stall_i),
    "output word vanished without being taken")
  `BCE_ASSERT_IMPLY(a_glyph_low,
    out_valid_o, out_word_o.glyph_utf8[5:0] == out_word_o.dot_pattern[5:0],
    "glyph trailing byte disagrees with the dot pattern")

endmodule
